>>> hw/rtl/pcpt_pkg.sv
// ----------------------------------------------------------------------------
// pcpt_pkg
// Shared types, register indexes, mode codes and saturation helpers of the
// point cloud pose transform.
// ----------------------------------------------------------------------------
package pcpt_pkg;

  localparam int unsigned PosW    = 32;
  localparam int unsigned QuatW   = 18;
  localparam int unsigned MatW    = 18;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;
  localparam int unsigned AccW    = 53;

  localparam logic [ModeW-1:0] MODE_PASS     = 2'd0;
  localparam logic [ModeW-1:0] MODE_SWAP     = 2'd1;
  localparam logic [ModeW-1:0] MODE_POSE     = 2'd2;
  localparam logic [ModeW-1:0] MODE_PASS_ALT = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_MODE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_QUAT_X  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_QUAT_Y  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_QUAT_Z  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_QUAT_W  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TRANS_X = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_TRANS_Y = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_TRANS_Z = 3'd7;

  localparam logic signed [MatW-1:0]  MAT_ONE    = 18'sd65536;
  localparam logic signed [QuatW-1:0] QUAT_W_RST = 18'sd16384;
  localparam logic [ModeW-1:0]        MODE_RST   = MODE_SWAP;

  typedef logic signed [PosW-1:0]  pos_t;
  typedef logic signed [QuatW-1:0] quat_comp_t;
  typedef logic signed [MatW-1:0]  mat_entry_t;
  typedef mat_entry_t mat_t [9];

  typedef struct packed {
    quat_comp_t x;
    quat_comp_t y;
    quat_comp_t z;
    quat_comp_t w;
  } quat_t;

  function automatic pos_t neg_sat32(input pos_t v);
    pos_t r;
    if (v == 32'sh8000_0000) begin
      r = 32'sh7FFF_FFFF;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  function automatic pos_t round_sat32(input logic signed [AccW-1:0] acc);
    logic signed [AccW-17:0] sh;
    pos_t r;
    sh = acc[AccW-1:16];
    if (sh > 37'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (sh < 37'sh1F_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = sh[PosW-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/pcpt_if.sv
// ----------------------------------------------------------------------------
// pcpt_if
// Valid/ready channels of the point cloud pose transform: input points,
// result points and register writes.
// ----------------------------------------------------------------------------
interface pcpt_in_if;
  logic                valid;
  logic                ready;
  pcpt_pkg::pos_t      pos_x;
  pcpt_pkg::pos_t      pos_y;
  pcpt_pkg::pos_t      pos_z;
  logic                point_ok;

  modport source (output valid, pos_x, pos_y, pos_z, point_ok, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, point_ok, output ready);
endinterface

interface pcpt_out_if;
  logic                valid;
  logic                ready;
  pcpt_pkg::pos_t      out_x;
  pcpt_pkg::pos_t      out_y;
  pcpt_pkg::pos_t      out_z;
  logic                out_ok;

  modport source (output valid, out_x, out_y, out_z, out_ok, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_ok, output ready);
endinterface

interface pcpt_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [pcpt_pkg::CfgIdxW-1:0]         index;
  logic [pcpt_pkg::CfgDatW-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/pcpt_rot_gen.sv
// ----------------------------------------------------------------------------
// pcpt_rot_gen
// Rotation matrix generator: squares and cross products of the quaternion on
// one shared multiplier, then one restoring divider, used in turn for each of
// the nine entries. Rerun after any quaternion write.
// ----------------------------------------------------------------------------
module pcpt_rot_gen (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            quat_wr_i,
  input  pcpt_pkg::quat_t quat_i,
  output logic            busy_o,
  output pcpt_pkg::mat_t  mat_o
);
  import pcpt_pkg::*;

  localparam int unsigned ProdW = 2 * QuatW;
  localparam int unsigned SumW  = ProdW + 1;
  localparam int unsigned NumW  = ProdW + 3;
  localparam int unsigned QuoW  = 17;
  localparam int unsigned RemW  = NumW - 1 + QuoW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PROD  = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_STORE = 3'd5;

  localparam logic [3:0] P_XX = 4'd0;
  localparam logic [3:0] P_YY = 4'd1;
  localparam logic [3:0] P_ZZ = 4'd2;
  localparam logic [3:0] P_WW = 4'd3;
  localparam logic [3:0] P_XY = 4'd4;
  localparam logic [3:0] P_XZ = 4'd5;
  localparam logic [3:0] P_YZ = 4'd6;
  localparam logic [3:0] P_WX = 4'd7;
  localparam logic [3:0] P_WY = 4'd8;
  localparam logic [3:0] P_WZ = 4'd9;
  localparam logic [3:0] LAST_ENTRY = 4'd8;
  localparam logic [4:0] LAST_BIT   = 5'd16;
  localparam logic [QuoW-1:0] QUO_ONE = 17'h1_0000;

  logic [2:0]             state_q, state_d;
  logic                   stale_q, stale_d;
  logic [3:0]             cnt_q, cnt_d;
  logic [4:0]             bit_q, bit_d;
  logic signed [ProdW-1:0] prod_q [10];
  logic [SumW-1:0]        dsum_q;
  logic [RemW-1:0]        rem_q;
  logic [RemW-1:0]        dsh_q;
  logic [QuoW-1:0]        quo_q;
  logic                   neg_q;
  mat_t                   mat_q;

  quat_comp_t              mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic signed [SumW:0]    dsum;
  logic signed [NumW-1:0]  num_sel;
  logic [NumW-2:0]         num_mag;
  logic                    div_ge;
  logic [QuoW-1:0]         quo_clamp;
  mat_entry_t              entry;

  always_comb begin
    unique case (cnt_q)
      P_XX:    begin mul_a = quat_i.x; mul_b = quat_i.x; end
      P_YY:    begin mul_a = quat_i.y; mul_b = quat_i.y; end
      P_ZZ:    begin mul_a = quat_i.z; mul_b = quat_i.z; end
      P_WW:    begin mul_a = quat_i.w; mul_b = quat_i.w; end
      P_XY:    begin mul_a = quat_i.x; mul_b = quat_i.y; end
      P_XZ:    begin mul_a = quat_i.x; mul_b = quat_i.z; end
      P_YZ:    begin mul_a = quat_i.y; mul_b = quat_i.z; end
      P_WX:    begin mul_a = quat_i.w; mul_b = quat_i.x; end
      P_WY:    begin mul_a = quat_i.w; mul_b = quat_i.y; end
      P_WZ:    begin mul_a = quat_i.w; mul_b = quat_i.z; end
      default: begin mul_a = '0;       mul_b = '0;       end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign dsum = (SumW+1)'(prod_q[P_XX]) + (SumW+1)'(prod_q[P_YY])
              + (SumW+1)'(prod_q[P_ZZ]) + (SumW+1)'(prod_q[P_WW]);

  always_comb begin
    unique case (cnt_q)
      4'd0: num_sel = NumW'(prod_q[P_WW]) + NumW'(prod_q[P_XX])
                    - NumW'(prod_q[P_YY]) - NumW'(prod_q[P_ZZ]);
      4'd1: num_sel = (NumW'(prod_q[P_XY]) - NumW'(prod_q[P_WZ])) <<< 1;
      4'd2: num_sel = (NumW'(prod_q[P_XZ]) + NumW'(prod_q[P_WY])) <<< 1;
      4'd3: num_sel = (NumW'(prod_q[P_XY]) + NumW'(prod_q[P_WZ])) <<< 1;
      4'd4: num_sel = NumW'(prod_q[P_WW]) - NumW'(prod_q[P_XX])
                    + NumW'(prod_q[P_YY]) - NumW'(prod_q[P_ZZ]);
      4'd5: num_sel = (NumW'(prod_q[P_YZ]) - NumW'(prod_q[P_WX])) <<< 1;
      4'd6: num_sel = (NumW'(prod_q[P_XZ]) - NumW'(prod_q[P_WY])) <<< 1;
      4'd7: num_sel = (NumW'(prod_q[P_YZ]) + NumW'(prod_q[P_WX])) <<< 1;
      4'd8: num_sel = NumW'(prod_q[P_WW]) - NumW'(prod_q[P_XX])
                    - NumW'(prod_q[P_YY]) + NumW'(prod_q[P_ZZ]);
      default: num_sel = '0;
    endcase
  end

  assign num_mag   = num_sel[NumW-1] ? (NumW-1)'(-num_sel) : (NumW-1)'(num_sel);
  assign div_ge    = (rem_q >= dsh_q);
  assign quo_clamp = (quo_q > QUO_ONE) ? QUO_ONE : quo_q;
  assign entry     = neg_q ? -$signed({1'b0, quo_clamp}) : $signed({1'b0, quo_clamp});

  always_comb begin
    state_d = state_q;
    stale_d = stale_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    if (quat_wr_i) begin
      state_d = ST_IDLE;
      stale_d = 1'b1;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (stale_q) begin
            stale_d = 1'b0;
            state_d = ST_PROD;
            cnt_d   = '0;
          end
        end
        ST_PROD: begin
          if (cnt_q == P_WZ) begin
            state_d = ST_SUM;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
        ST_SUM: begin
          cnt_d   = '0;
          state_d = (dsum == '0) ? ST_IDLE : ST_LOAD;
        end
        ST_LOAD: begin
          bit_d   = LAST_BIT;
          state_d = ST_DIV;
        end
        ST_DIV: begin
          if (bit_q == '0) begin
            state_d = ST_STORE;
          end else begin
            bit_d = bit_q - 5'd1;
          end
        end
        ST_STORE: begin
          if (cnt_q == LAST_ENTRY) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d   = cnt_q + 4'd1;
            state_d = ST_LOAD;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stale_q <= 1'b0;
      cnt_q   <= '0;
      bit_q   <= '0;
      for (int i = 0; i < 9; i++) begin
        mat_q[i] <= (i == 0 || i == 4 || i == 8) ? MAT_ONE : '0;
      end
    end else begin
      state_q <= state_d;
      stale_q <= stale_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      if (!quat_wr_i && state_q == ST_SUM && dsum == '0) begin
        for (int i = 0; i < 9; i++) begin
          mat_q[i] <= (i == 0 || i == 4 || i == 8) ? MAT_ONE : '0;
        end
      end
      if (!quat_wr_i && state_q == ST_STORE) begin
        mat_q[cnt_q] <= entry;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PROD) begin
      prod_q[cnt_q] <= mul_p;
    end
    if (state_q == ST_SUM) begin
      dsum_q <= dsum[SumW-1:0];
    end
    if (state_q == ST_LOAD) begin
      rem_q <= RemW'({num_mag, {QuoW{1'b0}}}) + RemW'(dsum_q);
      dsh_q <= RemW'({dsum_q, {QuoW{1'b0}}});
      quo_q <= '0;
      neg_q <= num_sel[NumW-1];
    end
    if (state_q == ST_DIV) begin
      rem_q <= div_ge ? (rem_q - dsh_q) : rem_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[QuoW-2:0], div_ge};
    end
  end

  assign busy_o = stale_q || (state_q != ST_IDLE);
  assign mat_o  = mat_q;

endmodule

>>> hw/rtl/point_cloud_pose_transform_core.sv
// ----------------------------------------------------------------------------
// point_cloud_pose_transform_core
// One request per cycle while the output is not stalled and no matrix update runs.
// Four register stages (input, nine multiplies, row sums, round and select),
// each with its own valid bit; a stalled output holds the pipe in place.
// After a quaternion write the matrix generator runs with the input held.
// Reset (async, active low) loads the register reset values and identity.
// ----------------------------------------------------------------------------
module point_cloud_pose_transform_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcpt_in_if.sink    pt_in_i,
  pcpt_out_if.source pt_out_o,
  pcpt_cfg_if.sink   cfg_i
);
  import pcpt_pkg::*;

  localparam int unsigned VecW  = PosW + 1;
  localparam int unsigned MulW  = VecW + MatW;

  typedef logic signed [VecW-1:0] vec_t;
  typedef logic signed [MulW-1:0] mul_t;
  typedef logic signed [AccW-1:0] acc_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             pose_ok;
    logic             dir_ok;
    pos_t             dir_x;
    pos_t             dir_y;
    pos_t             dir_z;
  } side_t;

  logic [ModeW-1:0] mode_q;
  quat_t            quat_q;
  pos_t             trans_q [3];
  logic             quat_wr;
  logic             gen_busy;
  mat_t             mat;

  logic  v1_q, v2_q, v3_q, v4_q;
  logic  adv1, adv2, adv3, adv4;
  logic  in_acc;
  vec_t  vec1_q [3];
  side_t side1_q, side2_q, side3_q, side1_d;
  mul_t  prod2_q [9];
  acc_t  acc3_q [3];
  pos_t  res_x_q, res_y_q, res_z_q;
  logic  res_ok_q;
  pos_t  res_x_d, res_y_d, res_z_d;
  logic  res_ok_d;

  // register file
  assign cfg_i.ready = 1'b1;
  assign quat_wr = cfg_i.valid && (cfg_i.index == REG_QUAT_X || cfg_i.index == REG_QUAT_Y ||
                                   cfg_i.index == REG_QUAT_Z || cfg_i.index == REG_QUAT_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_RST;
      quat_q     <= '{x: '0, y: '0, z: '0, w: QUAT_W_RST};
      trans_q[0] <= '0;
      trans_q[1] <= '0;
      trans_q[2] <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_MODE:    mode_q     <= cfg_i.data[ModeW-1:0];
        REG_QUAT_X:  quat_q.x   <= cfg_i.data[QuatW-1:0];
        REG_QUAT_Y:  quat_q.y   <= cfg_i.data[QuatW-1:0];
        REG_QUAT_Z:  quat_q.z   <= cfg_i.data[QuatW-1:0];
        REG_QUAT_W:  quat_q.w   <= cfg_i.data[QuatW-1:0];
        REG_TRANS_X: trans_q[0] <= cfg_i.data;
        REG_TRANS_Y: trans_q[1] <= cfg_i.data;
        REG_TRANS_Z: trans_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  pcpt_rot_gen u_rot_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .quat_wr_i (quat_wr),
    .quat_i    (quat_q),
    .busy_o    (gen_busy),
    .mat_o     (mat)
  );

  // stage advance
  assign adv4 = !v4_q || pt_out_o.ready;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign pt_in_i.ready = adv1 && !gen_busy;
  assign in_acc        = pt_in_i.valid && pt_in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_acc;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // stage 1: axis swap and direct results
  always_comb begin
    side1_d.mode    = mode_q;
    side1_d.pose_ok = pt_in_i.point_ok && (pt_in_i.pos_z > 32'sd0);
    if (mode_q == MODE_SWAP) begin
      side1_d.dir_ok = pt_in_i.point_ok;
      side1_d.dir_x  = pt_in_i.point_ok ? pt_in_i.pos_z : '0;
      side1_d.dir_y  = pt_in_i.point_ok ? neg_sat32(pt_in_i.pos_x) : '0;
      side1_d.dir_z  = pt_in_i.point_ok ? neg_sat32(pt_in_i.pos_y) : '0;
    end else begin
      side1_d.dir_ok = pt_in_i.point_ok;
      side1_d.dir_x  = pt_in_i.pos_x;
      side1_d.dir_y  = pt_in_i.pos_y;
      side1_d.dir_z  = pt_in_i.pos_z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_acc) begin
      side1_q   <= side1_d;
      vec1_q[0] <= VecW'(pt_in_i.pos_z);
      vec1_q[1] <= -VecW'(pt_in_i.pos_x);
      vec1_q[2] <= -VecW'(pt_in_i.pos_y);
    end
    // stage 2: nine products
    if (adv2 && v1_q) begin
      side2_q <= side1_q;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod2_q[3*r+c] <= MulW'(mat[3*r+c]) * MulW'(vec1_q[c]);
        end
      end
    end
    // stage 3: row sums with translation and rounding bias
    if (adv3 && v2_q) begin
      side3_q <= side2_q;
      for (int r = 0; r < 3; r++) begin
        acc3_q[r] <= AccW'(prod2_q[3*r]) + AccW'(prod2_q[3*r+1]) + AccW'(prod2_q[3*r+2])
                   + (AccW'(trans_q[r]) <<< 16) + AccW'(32'sd32768);
      end
    end
    // stage 4: round, saturate, select
    if (adv4 && v3_q) begin
      res_x_q  <= res_x_d;
      res_y_q  <= res_y_d;
      res_z_q  <= res_z_d;
      res_ok_q <= res_ok_d;
    end
  end

  always_comb begin
    if (side3_q.mode == MODE_POSE) begin
      res_ok_d = side3_q.pose_ok;
      res_x_d  = side3_q.pose_ok ? round_sat32(acc3_q[0]) : '0;
      res_y_d  = side3_q.pose_ok ? round_sat32(acc3_q[1]) : '0;
      res_z_d  = side3_q.pose_ok ? round_sat32(acc3_q[2]) : '0;
    end else begin
      res_ok_d = side3_q.dir_ok;
      res_x_d  = side3_q.dir_x;
      res_y_d  = side3_q.dir_y;
      res_z_d  = side3_q.dir_z;
    end
  end

  assign pt_out_o.valid  = v4_q;
  assign pt_out_o.out_x  = res_x_q;
  assign pt_out_o.out_y  = res_y_q;
  assign pt_out_o.out_z  = res_z_q;
  assign pt_out_o.out_ok = res_ok_q;

endmodule

>>> hw/rtl/pcpt_checker.sv
// ----------------------------------------------------------------------------
// pcpt_checker
// Port-level checks of the point cloud pose transform: request bookkeeping,
// input hold after a quaternion write, output hold under backpressure.
// ----------------------------------------------------------------------------
module pcpt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input pcpt_pkg::pos_t               out_x_i,
  input pcpt_pkg::pos_t               out_y_i,
  input pcpt_pkg::pos_t               out_z_i,
  input logic                         out_ok_i,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_i,
  input logic [pcpt_pkg::CfgIdxW-1:0] cfg_index_i
);
  import pcpt_pkg::*;

  localparam logic [2:0] MAX_INFLIGHT = 3'd4;

  logic       in_acc, out_acc, cfg_acc;
  logic [2:0] cnt_q, cnt_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign cfg_acc = cfg_valid_i && cfg_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) cnt_d = cnt_q + 3'd1;
    if (!in_acc && out_acc) cnt_d = cnt_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> cnt_q != '0)
    else $error("result delivered without pending request");

  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_INFLIGHT)
    else $error("more requests in flight than pipeline stages");

  a_quat_write_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc && (cfg_index_i == REG_QUAT_X || cfg_index_i == REG_QUAT_Y ||
                cfg_index_i == REG_QUAT_Z || cfg_index_i == REG_QUAT_W)
    |=> !in_acc)
    else $error("request accepted while rotation matrix is stale");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i
    |=> out_valid_i && $stable({out_x_i, out_y_i, out_z_i, out_ok_i}))
    else $error("stalled result changed");

endmodule

bind point_cloud_pose_transform_core pcpt_checker u_pcpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pt_in_i.valid),
  .in_ready_i  (pt_in_i.ready),
  .out_valid_i (pt_out_o.valid),
  .out_ready_i (pt_out_o.ready),
  .out_x_i     (pt_out_o.out_x),
  .out_y_i     (pt_out_o.out_y),
  .out_z_i     (pt_out_o.out_z),
  .out_ok_i    (pt_out_o.out_ok),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .cfg_index_i (cfg_i.index)
);
